// ===== rtl/staged_task_watchdog_unit_defines.svh =====
// Assertion macros for the staged task watchdog.
// Included by the top level; needs no other file.
`ifndef STAGED_TASK_WATCHDOG_UNIT_DEFINES_SVH
`define STAGED_TASK_WATCHDOG_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define STW_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
`define STW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define STW_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define STW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/stw_pkg.sv =====
// Shared types and constants of the staged task watchdog.
// Used by stw_eval and the top level; depends on nothing.
`default_nettype none

package stw_pkg;

    localparam int TIME_W    = 32;
    localparam int TASK_ID_W = 3;
    localparam int STAGE_W   = 2;
    localparam int CFG_IDX_W = 3;

    localparam logic [STAGE_W-1:0] STAGE_OK     = 2'd0;
    localparam logic [STAGE_W-1:0] STAGE_WARNED = 2'd1;
    localparam logic [STAGE_W-1:0] STAGE_SOFT   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_WARN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOFT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HARD      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_WARN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_SOFT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_HARD = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPECIAL   = 3'd6;

    localparam logic [TIME_W-1:0]    RST_WARN      = 32'd15000;
    localparam logic [TIME_W-1:0]    RST_SOFT      = 32'd30000;
    localparam logic [TIME_W-1:0]    RST_HARD      = 32'd60000;
    localparam logic [TIME_W-1:0]    RST_LONG_WARN = 32'd45000;
    localparam logic [TIME_W-1:0]    RST_LONG_SOFT = 32'd90000;
    localparam logic [TIME_W-1:0]    RST_LONG_HARD = 32'd180000;
    localparam logic [TASK_ID_W-1:0] RST_SPECIAL   = 3'd2;

    typedef struct packed {
        logic [TIME_W-1:0] warn;
        logic [TIME_W-1:0] soft_lim;
        logic [TIME_W-1:0] hard;
    } t_limits;

    typedef struct packed {
        logic [STAGE_W-1:0] stage;
        logic               warn_ev;
        logic               soft_ev;
        logic               rec_ev;
        logic               hard_ev;
    } t_eval_res;

endpackage

`default_nettype wire

// ===== rtl/stw_eval.sv =====
// Stage decision for one task: compares the elapsed time with its limits.
// Depends on stw_pkg for the limit and result types.
`default_nettype none

module stw_eval (
    input  wire logic                            i_mon,
    input  wire logic [stw_pkg::TIME_W-1:0]      i_elapsed,
    input  wire logic [stw_pkg::STAGE_W-1:0]     i_stage,
    input  wire stw_pkg::t_limits                i_lim,
    output stw_pkg::t_eval_res                   o_res
);

    logic [stw_pkg::STAGE_W-1:0] w_stage;

    always_comb begin
        o_res         = '0;
        o_res.stage   = i_stage;
        w_stage       = i_stage;
        if (i_mon) begin
            if (i_elapsed <= i_lim.warn) begin
                if (i_stage != stw_pkg::STAGE_OK) begin
                    o_res.rec_ev = 1'b1;
                    o_res.stage  = stw_pkg::STAGE_OK;
                end
            end else begin
                if (i_stage == stw_pkg::STAGE_OK) begin
                    w_stage       = stw_pkg::STAGE_WARNED;
                    o_res.warn_ev = 1'b1;
                end
                if ((w_stage < stw_pkg::STAGE_SOFT) && (i_elapsed > i_lim.soft_lim)) begin
                    w_stage       = stw_pkg::STAGE_SOFT;
                    o_res.soft_ev = 1'b1;
                end
                o_res.stage   = w_stage;
                o_res.hard_ev = (i_elapsed > i_lim.hard);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/staged_task_watchdog_unit.sv =====
// Top level of the staged task watchdog: state memories, sweep sequencer and ports.
// Depends on stw_pkg, stw_eval and staged_task_watchdog_unit_defines.svh.
//
// A heartbeat transaction writes the task's time straight into the heartbeat
// memory. A check transaction sweeps the tasks from index 0 up, taking each task
// through a memory read, the elapsed time, and the compare and write back; the
// sweep waits while the output is stalled, and a hard timeout ends it early. The
// pace is set by the read-modify-write of one entry at a time on the single port
// of the stage memory. Both memories have a valid bit per entry, so reset and a
// hard timeout clear all task state at once. No new input is taken during a sweep;
// configuration writes are taken at any time.
`default_nettype none
`include "staged_task_watchdog_unit_defines.svh"

module staged_task_watchdog_unit #(
    parameter int MONITORED_TASKS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input stream.
    input  wire logic        i_s_tvalid,
    output      logic        o_s_tready,
    input  wire logic [39:0] i_s_tdata,  // task_id[2:0], now_ms[34:3], zero[39:35]
    input  wire logic        i_s_tuser,  // action[0]
    // Result stream.
    output      logic        o_m_tvalid,
    input  wire logic        i_m_tready,
    // task_index[2:0], monitored[3], stage[5:4], age_ms[37:6], warn_event[38],
    // soft_event[39], recovered_event[40], hard_event[41], zero[47:42]
    output      logic [47:0] o_m_tdata,
    output      logic        o_m_tlast,
    // Configuration writes.
    input  wire logic        i_cfg_valid,
    output      logic        o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    localparam int IW = (MONITORED_TASKS > 1) ? $clog2(MONITORED_TASKS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(MONITORED_TASKS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CALC,
        S_EVAL
    } t_state;

    t_state r_state;

    logic [stw_pkg::TIME_W-1:0]    r_warn, r_soft, r_hard;
    logic [stw_pkg::TIME_W-1:0]    r_lwarn, r_lsoft, r_lhard;
    logic [stw_pkg::TASK_ID_W-1:0] r_special;

    logic [stw_pkg::TIME_W-1:0]  r_time_mem  [MONITORED_TASKS];
    logic [stw_pkg::STAGE_W-1:0] r_stage_mem [MONITORED_TASKS];
    logic [MONITORED_TASKS-1:0]  r_tv;
    logic [MONITORED_TASKS-1:0]  r_sv;

    logic [stw_pkg::TIME_W-1:0]  r_rd_time;
    logic [stw_pkg::STAGE_W-1:0] r_rd_stage;
    logic                        r_rd_tv;
    logic                        r_rd_sv;

    logic [IW-1:0]               r_idx;
    logic [stw_pkg::TIME_W-1:0]  r_now;
    logic                        r_mon;
    logic [stw_pkg::TIME_W-1:0]  r_el;
    logic [stw_pkg::STAGE_W-1:0] r_stg;
    stw_pkg::t_limits            r_lim;

    logic                        r_out_valid;
    logic [47:0]                 r_out_data;
    logic                        r_out_last;

    logic                        w_in_acc;
    logic                        w_hb_wr;
    logic [IW-1:0]               w_hb_addr;
    logic [stw_pkg::TIME_W-1:0]  w_in_now;
    logic [stw_pkg::TIME_W-1:0]  w_hb;
    logic [stw_pkg::STAGE_W-1:0] w_stg;
    logic                        w_mon;
    logic                        w_special;
    logic                        w_load;
    logic                        w_last;
    stw_pkg::t_eval_res          w_res;

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;
    assign o_m_tlast   = r_out_last;

    assign w_in_acc  = i_s_tvalid && o_s_tready;
    assign w_in_now  = i_s_tdata[34:3];
    assign w_hb_addr = IW'(i_s_tdata[2:0]);
    assign w_hb_wr   = w_in_acc && !i_s_tuser
                       && ({29'd0, i_s_tdata[2:0]} < 32'(MONITORED_TASKS));

    assign w_hb      = r_rd_tv ? r_rd_time : '0;
    assign w_stg     = r_rd_sv ? r_rd_stage : stw_pkg::STAGE_OK;
    assign w_mon     = (w_hb != '0) && (w_hb <= r_now);
    assign w_special = (32'(r_idx) == 32'(r_special));

    assign w_load = (r_state == S_EVAL) && (!r_out_valid || i_m_tready);
    assign w_last = w_res.hard_ev || (r_idx == LAST_IDX);

    stw_eval u_eval (
        .i_mon     (r_mon),
        .i_elapsed (r_el),
        .i_stage   (r_stg),
        .i_lim     (r_lim),
        .o_res     (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warn    <= stw_pkg::RST_WARN;
            r_soft    <= stw_pkg::RST_SOFT;
            r_hard    <= stw_pkg::RST_HARD;
            r_lwarn   <= stw_pkg::RST_LONG_WARN;
            r_lsoft   <= stw_pkg::RST_LONG_SOFT;
            r_lhard   <= stw_pkg::RST_LONG_HARD;
            r_special <= stw_pkg::RST_SPECIAL;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                stw_pkg::CFG_WARN:      r_warn    <= i_cfg_data;
                stw_pkg::CFG_SOFT:      r_soft    <= i_cfg_data;
                stw_pkg::CFG_HARD:      r_hard    <= i_cfg_data;
                stw_pkg::CFG_LONG_WARN: r_lwarn   <= i_cfg_data;
                stw_pkg::CFG_LONG_SOFT: r_lsoft   <= i_cfg_data;
                stw_pkg::CFG_LONG_HARD: r_lhard   <= i_cfg_data;
                stw_pkg::CFG_SPECIAL:   r_special <= i_cfg_data[stw_pkg::TASK_ID_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_hb_wr) begin
            r_time_mem[w_hb_addr] <= w_in_now;
        end
        r_rd_time <= r_time_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (w_load && r_mon) begin
            r_stage_mem[r_idx] <= w_res.stage;
        end
        r_rd_stage <= r_stage_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tv    <= '0;
            r_sv    <= '0;
            r_rd_tv <= 1'b0;
            r_rd_sv <= 1'b0;
        end else begin
            r_rd_tv <= r_tv[r_idx];
            r_rd_sv <= r_sv[r_idx];
            if (w_load && w_res.hard_ev) begin
                r_tv <= '0;
                r_sv <= '0;
            end else begin
                if (w_hb_wr) begin
                    r_tv[w_hb_addr] <= 1'b1;
                end
                if (w_load && r_mon) begin
                    r_sv[r_idx] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc && i_s_tuser) begin
                        r_idx   <= '0;
                        r_now   <= w_in_now;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_CALC;
                end
                S_CALC: begin
                    r_mon   <= w_mon;
                    r_el    <= w_mon ? (r_now - w_hb) : '0;
                    r_stg   <= w_stg;
                    r_lim   <= w_special ? {r_lwarn, r_lsoft, r_lhard}
                                         : {r_warn, r_soft, r_hard};
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    if (w_load) begin
                        r_out_last  <= w_last;
                        r_out_data  <= {6'd0, w_res.hard_ev, w_res.rec_ev, w_res.soft_ev,
                                        w_res.warn_ev, r_el, w_res.stage, r_mon,
                                        3'(r_idx)};
                        if (w_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + IW'(1);
                            r_state <= S_READ;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `STW_ASSERT_SAME(a_hard_is_last, i_clk, i_rst_n, o_m_tvalid && o_m_tdata[41],
                     o_m_tlast, "hard timeout result not marked last")
    `STW_ASSERT_NEXT(a_hard_clears, i_clk, i_rst_n, w_load && w_res.hard_ev,
                     (r_tv == '0) && (r_sv == '0) && (r_state == S_IDLE),
                     "hard timeout did not clear task state")
    `STW_ASSERT_NEXT(a_check_starts, i_clk, i_rst_n, w_in_acc && i_s_tuser,
                     (r_state == S_READ) && (r_idx == '0),
                     "check transaction did not start a sweep")

endmodule

`default_nettype wire
